### rtl/core/mirrored_stripe_disk_mapper_unit_macros.svh
// assertion macros used by the checker file
`ifndef MIRRORED_STRIPE_DISK_MAPPER_UNIT_MACROS_SVH
`define MIRRORED_STRIPE_DISK_MAPPER_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define MSDM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mapper check failed");

// next-cycle implication, off during reset
`define MSDM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mapper check failed");

// next-cycle implication that also holds across reset
`define MSDM_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("mapper check failed");

`endif

### rtl/core/msdm_pkg.sv
// shared types, constants and helpers of the mirrored stripe disk mapper
package msdm_pkg;

  localparam int NUM_DISKS     = 4;
  localparam int FIRST_DISK    = 1;
  localparam int DISK_BLOCKS   = 1024;
  localparam int HEADER_BLOCKS = 1;

  localparam int HALF_DISKS = NUM_DISKS / 2;
  localparam int unsigned CAPACITY = NUM_DISKS * (DISK_BLOCKS - HEADER_BLOCKS) / 2;
  localparam int unsigned DISK_END = FIRST_DISK + NUM_DISKS;

  localparam int OP_W   = 2;
  localparam int BLK_W  = 16;
  localparam int DISK_W = 4;
  localparam int TBLK_W = 10;
  localparam int ST_W   = 3;
  localparam int MASK_W = FIRST_DISK + NUM_DISKS;
  localparam int REM_W  = $clog2(HALF_DISKS);

  localparam int DIV_SHIFT = 20;
  localparam int unsigned DIV_MULT = (1 << DIV_SHIFT) / HALF_DISKS;
  localparam int PROD_W = BLK_W + DIV_SHIFT;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [OP_W-1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_FAIL   = 2'd2,
    OP_REPAIR = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK          = 3'd0,
    ST_BAD_BLOCK   = 3'd1,
    ST_BOTH_FAULTY = 3'd2,
    ST_BAD_DISK    = 3'd3,
    ST_ALREADY     = 3'd4,
    ST_NOT_FAULTY  = 3'd5,
    ST_PAIR_FAULTY = 3'd6
  } status_t;

  typedef struct packed {
    op_t                opcode;
    logic [BLK_W-1:0]   block_number;
    logic [DISK_W-1:0]  disk_number;
  } item_t;

  typedef struct packed {
    status_t            status;
    logic               command_valid;
    logic               command_write;
    logic [DISK_W-1:0]  target_disk;
    logic [TBLK_W-1:0]  target_block;
    logic               copy_request;
    logic [DISK_W-1:0]  copy_source;
  } result_t;

  typedef struct packed {
    result_t first;
    result_t second;
    logic    two;
  } pair_t;

  function automatic logic mask_bit(input logic [MASK_W-1:0] mask,
                                    input logic [DISK_W-1:0] disk);
    logic [15:0] ext;
    ext = 16'(mask);
    return ext[disk];
  endfunction

  function automatic logic [MASK_W-1:0] disk_onehot(input logic [DISK_W-1:0] disk);
    logic [15:0] ext;
    ext = 16'(1) << disk;
    return MASK_W'(ext);
  endfunction

endpackage

### rtl/core/msdm_map.sv
// request decode, block mapping and fault mask update
module msdm_map (
  input  msdm_pkg::item_t                  item,
  input  logic [msdm_pkg::MASK_W-1:0]      mask,
  output msdm_pkg::pair_t                  pair,
  output logic [msdm_pkg::MASK_W-1:0]      mask_next
);

  logic [msdm_pkg::PROD_W-1:0] prod;
  logic [msdm_pkg::BLK_W-1:0]  q_est;
  logic [msdm_pkg::BLK_W-1:0]  r_est;
  logic [msdm_pkg::BLK_W-1:0]  q_fix;
  logic [msdm_pkg::BLK_W-1:0]  r_fix;
  logic [msdm_pkg::REM_W-1:0]  rem;
  logic [msdm_pkg::DISK_W-1:0] data_disk;
  logic [msdm_pkg::DISK_W-1:0] mirror;
  logic [msdm_pkg::TBLK_W-1:0] phys_blk;
  logic [msdm_pkg::DISK_W-1:0] partner;
  logic                        in_range;
  logic                        disk_ok;
  logic                        df;
  logic                        mf;
  logic                        dn_faulty;
  logic                        pt_faulty;

  // block / half disk count by reciprocal with one correction step
  assign prod  = msdm_pkg::PROD_W'(item.block_number) *
                 msdm_pkg::PROD_W'(msdm_pkg::DIV_MULT);
  assign q_est = prod[msdm_pkg::PROD_W-1:msdm_pkg::DIV_SHIFT];
  assign r_est = item.block_number -
                 msdm_pkg::BLK_W'(q_est * msdm_pkg::BLK_W'(msdm_pkg::HALF_DISKS));

  always_comb begin
    if (r_est >= msdm_pkg::BLK_W'(msdm_pkg::HALF_DISKS)) begin
      q_fix = q_est + msdm_pkg::BLK_W'(1);
      r_fix = r_est - msdm_pkg::BLK_W'(msdm_pkg::HALF_DISKS);
    end else begin
      q_fix = q_est;
      r_fix = r_est;
    end
  end

  assign rem       = msdm_pkg::REM_W'(r_fix);
  assign data_disk = msdm_pkg::DISK_W'(msdm_pkg::FIRST_DISK) +
                     msdm_pkg::DISK_W'({rem, 1'b0});
  assign mirror    = data_disk + msdm_pkg::DISK_W'(1);
  assign phys_blk  = msdm_pkg::TBLK_W'(q_fix + msdm_pkg::BLK_W'(msdm_pkg::HEADER_BLOCKS));
  assign in_range  = 32'(item.block_number) < msdm_pkg::CAPACITY;
  assign disk_ok   = (32'(item.disk_number) >= 32'(msdm_pkg::FIRST_DISK)) &&
                     (32'(item.disk_number) < msdm_pkg::DISK_END);
  assign partner   = msdm_pkg::DISK_W'(msdm_pkg::FIRST_DISK) +
                     ((item.disk_number - msdm_pkg::DISK_W'(msdm_pkg::FIRST_DISK)) ^
                      msdm_pkg::DISK_W'(1));
  assign df        = msdm_pkg::mask_bit(mask, data_disk);
  assign mf        = msdm_pkg::mask_bit(mask, mirror);
  assign dn_faulty = msdm_pkg::mask_bit(mask, item.disk_number);
  assign pt_faulty = msdm_pkg::mask_bit(mask, partner);

  always_comb begin
    pair      = '0;
    mask_next = mask;
    pair.first.status  = msdm_pkg::ST_OK;
    pair.second.status = msdm_pkg::ST_OK;
    unique case (item.opcode)
      msdm_pkg::OP_READ, msdm_pkg::OP_WRITE: begin
        if (!in_range) begin
          pair.first.status = msdm_pkg::ST_BAD_BLOCK;
        end else if (df && mf) begin
          pair.first.status = msdm_pkg::ST_BOTH_FAULTY;
        end else begin
          pair.first.command_valid = 1'b1;
          pair.first.command_write = (item.opcode == msdm_pkg::OP_WRITE);
          pair.first.target_disk   = df ? mirror : data_disk;
          pair.first.target_block  = phys_blk;
          // healthy pair on write: data disk then mirror
          if (item.opcode == msdm_pkg::OP_WRITE && !df && !mf) begin
            pair.two                  = 1'b1;
            pair.second.command_valid = 1'b1;
            pair.second.command_write = 1'b1;
            pair.second.target_disk   = mirror;
            pair.second.target_block  = phys_blk;
          end
        end
      end
      msdm_pkg::OP_FAIL: begin
        if (!disk_ok) begin
          pair.first.status = msdm_pkg::ST_BAD_DISK;
        end else if (dn_faulty) begin
          pair.first.status = msdm_pkg::ST_ALREADY;
        end else begin
          mask_next = mask | msdm_pkg::disk_onehot(item.disk_number);
        end
      end
      msdm_pkg::OP_REPAIR: begin
        if (!disk_ok) begin
          pair.first.status = msdm_pkg::ST_BAD_DISK;
        end else if (!dn_faulty) begin
          pair.first.status = msdm_pkg::ST_NOT_FAULTY;
        end else begin
          mask_next = mask & ~msdm_pkg::disk_onehot(item.disk_number);
          if (pt_faulty) begin
            pair.first.status = msdm_pkg::ST_PAIR_FAULTY;
          end else begin
            pair.first.command_valid = 1'b1;
            pair.first.target_disk   = item.disk_number;
            pair.first.copy_request  = 1'b1;
            pair.first.copy_source   = partner;
          end
        end
      end
    endcase
  end

endmodule

### rtl/core/msdm_outbuf.sv
// result register that hands out one or two results per request
module msdm_outbuf (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             load,
  input  msdm_pkg::pair_t                  pair_in,
  output logic                             can_load,
  output logic                             out_valid,
  input  logic                             out_ready,
  output msdm_pkg::result_t                out_result,
  output logic                             out_last
);

  logic            valid;
  logic            second;
  msdm_pkg::pair_t pair;

  assign out_valid  = valid;
  assign out_result = second ? pair.second : pair.first;
  assign out_last   = second || !pair.two;
  assign can_load   = !valid || (out_ready && out_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= 1'b0;
      second <= 1'b0;
    end else if (load) begin
      valid  <= 1'b1;
      second <= 1'b0;
    end else if (valid && out_ready) begin
      if (out_last) begin
        valid  <= 1'b0;
        second <= 1'b0;
      end else begin
        second <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pair <= pair_in;
    end
  end

endmodule

### rtl/core/mirrored_stripe_disk_mapper_unit.sv
// top level of the mirrored stripe disk mapper
//
// requests arrive on the s_ stream: s_tuser carries the opcode (read, write,
// fail disk, repair disk), s_tdata the logical block and the disk number.
// results leave on the m_ stream, one or two per request, m_tlast set on the
// final result of each request. a write to a healthy pair gives two results,
// data disk first, then mirror; every other request gives one.
// a request is held in an input register, mapped and checked against the
// fault mask combinationally, and lands in a result register that drives
// m_tvalid, m_tdata and m_tlast.
// the result register frees up when its last result is taken, so the input
// register moves on in that same cycle: one request per cycle for single
// result requests while m_tready stays high; a mirrored write holds the
// result register until both its results have left the single result port.
// the fault mask changes as a request leaves the input register, so later
// requests always see the effect of earlier fail and repair requests.
// reset clears both registers and marks every disk healthy.
// while m_tready is low the current result holds, and s_tready drops once
// the input register is also occupied.
module mirrored_stripe_disk_mapper_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // block_number, disk_number, zero pad
  input  logic [msdm_pkg::IN_DATA_W-1:0]     s_tdata,
  // opcode
  input  logic [msdm_pkg::OP_W-1:0]          s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // status, command_valid, command_write, target_disk, target_block,
  // copy_request, copy_source
  output logic [msdm_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic                               m_tlast
);

  logic                          a_valid;
  msdm_pkg::item_t               a_item;
  logic [msdm_pkg::MASK_W-1:0]   fault_mask;
  logic [msdm_pkg::MASK_W-1:0]   fault_mask_next;
  msdm_pkg::pair_t               pair;
  logic                          can_load;
  logic                          advance;
  msdm_pkg::result_t             res;

  assign advance  = a_valid && can_load;
  assign s_tready = !a_valid || can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid    <= 1'b0;
      fault_mask <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        a_valid <= 1'b1;
      end else if (advance) begin
        a_valid <= 1'b0;
      end
      if (advance) begin
        fault_mask <= fault_mask_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      a_item.opcode       <= msdm_pkg::op_t'(s_tuser);
      a_item.block_number <= s_tdata[msdm_pkg::BLK_W-1:0];
      a_item.disk_number  <= s_tdata[msdm_pkg::BLK_W +: msdm_pkg::DISK_W];
    end
  end

  msdm_map u_map (
    .item      (a_item),
    .mask      (fault_mask),
    .pair      (pair),
    .mask_next (fault_mask_next)
  );

  msdm_outbuf u_outbuf (
    .clk        (clk),
    .rst        (rst),
    .load       (advance),
    .pair_in    (pair),
    .can_load   (can_load),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (res),
    .out_last   (m_tlast)
  );

  assign m_tdata = {res.copy_source, res.copy_request, res.target_block,
                    res.target_disk, res.command_write, res.command_valid,
                    res.status};

endmodule

### rtl/core/msdm_checker.sv
// port-level checks of the mapper, bound to the top level
`include "mirrored_stripe_disk_mapper_unit_macros.svh"

module msdm_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_tvalid,
  input logic                               s_tready,
  input logic [msdm_pkg::IN_DATA_W-1:0]     s_tdata,
  input logic [msdm_pkg::OP_W-1:0]          s_tuser,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [msdm_pkg::OUT_DATA_W-1:0]    m_tdata,
  input logic                               m_tlast
);

  logic                        unused_in;
  logic [msdm_pkg::ST_W-1:0]   status;
  logic                        cmd_valid;
  logic                        cmd_write;
  logic [msdm_pkg::DISK_W-1:0] disk;
  logic [msdm_pkg::TBLK_W-1:0] blk;
  logic                        copy;
  logic [msdm_pkg::DISK_W-1:0] src;
  logic                        stall;
  logic                        not_last;
  logic                        first_ok;
  logic                        last_write;
  logic                        next_slot;
  logic                        copy_out;
  logic                        plain_cmd;
  logic [msdm_pkg::DISK_W-1:0] prev_disk;
  logic [msdm_pkg::TBLK_W-1:0] prev_blk;

  assign unused_in = s_tvalid ^ s_tready ^ (^s_tdata) ^ (^s_tuser);

  assign status    = m_tdata[2:0];
  assign cmd_valid = m_tdata[3];
  assign cmd_write = m_tdata[4];
  assign disk      = m_tdata[8:5];
  assign blk       = m_tdata[18:9];
  assign copy      = m_tdata[19];
  assign src       = m_tdata[23:20];

  assign stall      = m_tvalid && !m_tready;
  assign not_last   = m_tvalid && !m_tlast;
  assign first_ok   = (status == msdm_pkg::ST_OK) && cmd_valid && cmd_write && !copy;
  assign last_write = m_tvalid && m_tlast && cmd_write;
  assign next_slot  = (blk == prev_blk) && (disk == prev_disk + msdm_pkg::DISK_W'(1));
  assign copy_out   = m_tvalid && copy;
  assign plain_cmd  = cmd_valid && !cmd_write && (blk == '0);

  // fields of the previous cycle
  always_ff @(posedge clk) begin
    prev_disk <= disk;
    prev_blk  <= blk;
  end

  // nothing comes out right after reset
  `MSDM_ASSERT_NEXT_ALWAYS(a_reset_idle, clk, rst, !m_tvalid && !unused_in || !m_tvalid)

  // a stalled result holds
  `MSDM_ASSERT_NEXT(a_stall_hold, clk, rst, stall, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

  // a non-final result is always the data disk write of a mirrored pair
  `MSDM_ASSERT_IMPLY(a_first_of_pair, clk, rst, not_last, first_ok)

  // the mirror write follows at once, same block, next disk
  `MSDM_ASSERT_NEXT(a_mirror_follows, clk, rst, not_last && m_tready, last_write && next_slot)

  // a copy request is a plain command with no block
  `MSDM_ASSERT_IMPLY(a_copy_shape, clk, rst, copy_out, plain_cmd && disk != src)

endmodule

bind mirrored_stripe_disk_mapper_unit msdm_checker u_msdm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
